// File: rtl/wbc_pkg.sv
// Shared types and constants of the two-level write-back cache.
`timescale 1ns / 1ps
package wbc_pkg;

    localparam int COST_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_RD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_RD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR = 3'd5;

    localparam logic [COST_W-1:0] RST_L1_COST  = 16'd1;
    localparam logic [COST_W-1:0] RST_L2_COST  = 16'd10;
    localparam logic [COST_W-1:0] RST_MEM_COST = 16'd100;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
        logic [31:0] write_word;
    } t_req;

    typedef struct packed {
        logic [31:0]       read_word;
        logic              l1_hit;
        logic              l2_hit;
        logic [STEP_W-1:0] access_cost;
        logic [31:0]       total_cost;
        logic              error;
    } t_rsp;

    typedef enum logic [3:0] {
        CK_L2_TO_MEM = 4'b0001,
        CK_MEM_TO_L2 = 4'b0010,
        CK_L1_TO_L2  = 4'b0100,
        CK_L2_TO_L1  = 4'b1000
    } t_copy;

endpackage

// File: rtl/wbc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module wbc_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/two_level_write_back_cache_core.sv
// Top level: sequencer of the two-level direct-mapped write-back cache.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  request  | start / busy           | i_req  (cmd, address, word)
//  result   | o_rsp_valid strobe     | o_rsp  (word, hits, costs)
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// An L1 hit passes through the lookup, access and finish states before its
// result is shown; an out-of-range address gives its result in the cycle
// after acceptance. Block transfers run one at a time, and a miss with
// dirty victims at both levels runs about six of them.
// After reset a clearing pass over the tag RAMs and the backing memory
// holds busy high; config writes are taken always.
// Results cannot be stalled.
`timescale 1ns / 1ps
module two_level_write_back_cache_core #(
    parameter int L1_LINES   = 256,
    parameter int L2_LINES   = 512,
    parameter int LINE_BYTES = 64,
    parameter int MEM_BYTES  = 1048576
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  wbc_pkg::t_req                  i_req,
    output logic                           o_rsp_valid,
    output wbc_pkg::t_rsp                  o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wbc_pkg::COST_W-1:0]     i_cfg_data
);

    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int W_W     = OFF_W - 2;
    localparam int WPL     = LINE_BYTES / 4;
    localparam int MEM_W   = $clog2(MEM_BYTES);
    localparam int BLK_W   = MEM_W - OFF_W;
    localparam int MWORD_W = MEM_W - 2;
    localparam int IDX1_W  = $clog2(L1_LINES);
    localparam int IDX2_W  = $clog2(L2_LINES);
    localparam int TAG1_W  = (BLK_W > IDX1_W) ? BLK_W - IDX1_W : 1;
    localparam int TAG2_W  = (BLK_W > IDX2_W) ? BLK_W - IDX2_W : 1;
    localparam int T1_W    = TAG1_W + 2;
    localparam int T2_W    = TAG2_W + 2;
    localparam int CLR_A   = (MWORD_W > IDX1_W) ? MWORD_W : IDX1_W;
    localparam int CLR_W   = (CLR_A > IDX2_W) ? CLR_A : IDX2_W;
    localparam int STEP_W  = wbc_pkg::STEP_W;
    localparam int COST_W  = wbc_pkg::COST_W;

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOK1  = 9'b000000100,
        S_E_RD   = 9'b000001000,
        S_E_LOOK = 9'b000010000,
        S_XFER   = 9'b000100000,
        S_COPY   = 9'b001000000,
        S_ACC    = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    wbc_pkg::t_req      r_req;
    wbc_pkg::t_copy     r_ck;
    logic [COST_W-1:0]  r_cfg [6];
    logic [CLR_W-1:0]   r_clr;
    logic [W_W:0]       r_cnt;
    logic [BLK_W-1:0]   r_b;
    logic [BLK_W-1:0]   r_vb2;
    logic               r_vict;
    logic               r_hit1, r_hit2, r_ehit;
    logic [T1_W-1:0]    r_t1;
    logic [STEP_W-1:0]  r_step;
    logic [31:0]        r_total;
    logic               r_ov;
    wbc_pkg::t_rsp      r_rsp;

    logic               in_err, accept;
    logic [BLK_W-1:0]   blk;
    logic [IDX1_W-1:0]  idx1, in_idx1;
    logic [TAG1_W-1:0]  tag1;
    logic [W_W-1:0]     word;
    logic [IDX2_W-1:0]  idx2;
    logic [TAG2_W-1:0]  btag2;
    logic [W_W-1:0]     rd_w, wr_w;
    logic               copy_end;
    logic               chg;
    logic [COST_W-1:0]  chg_val;

    logic               t1_we;
    logic [IDX1_W-1:0]  t1_waddr, t1_raddr;
    logic [T1_W-1:0]    t1_wdata, t1_rdata;
    logic               t2_we;
    logic [IDX2_W-1:0]  t2_waddr;
    logic [T2_W-1:0]    t2_wdata, t2_rdata;
    logic               d1_we;
    logic [IDX1_W+W_W-1:0] d1_waddr, d1_raddr;
    logic [31:0]        d1_wdata, d1_rdata;
    logic               d2_we;
    logic [IDX2_W+W_W-1:0] d2_waddr, d2_raddr;
    logic [31:0]        d2_wdata, d2_rdata;
    logic               m_we;
    logic [MWORD_W-1:0] m_waddr, m_raddr;
    logic [31:0]        m_wdata, m_rdata;

    assign accept  = start && !busy;
    assign in_err  = (i_req.address >> MEM_W) != 32'd0;
    assign in_idx1 = IDX1_W'(i_req.address >> OFF_W);
    assign blk     = BLK_W'(r_req.address >> OFF_W);
    assign idx1    = IDX1_W'(blk);
    assign tag1    = TAG1_W'(blk >> IDX1_W);
    assign word    = r_req.address[OFF_W-1:2];
    assign idx2    = IDX2_W'(r_b);
    assign btag2   = TAG2_W'(r_b >> IDX2_W);
    assign rd_w    = r_cnt[W_W-1:0];
    assign wr_w    = W_W'(r_cnt - 1'b1);
    assign copy_end = (r_state == S_COPY) && (r_cnt == (W_W+1)'(WPL));
    assign busy    = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_ov;
    assign o_rsp   = r_rsp;

    always_comb begin
        t1_raddr = (r_state == S_IDLE) ? in_idx1 : idx1;
        t1_we    = 1'b0;
        t1_waddr = idx1;
        t1_wdata = {1'b1, ((r_hit1 && r_t1[TAG1_W]) || r_req.cmd), tag1};
        t2_we    = 1'b0;
        t2_waddr = idx2;
        t2_wdata = {1'b1, 1'b0, btag2};
        d1_raddr = (r_state == S_ACC) ? {idx1, word} : {idx1, rd_w};
        d1_we    = 1'b0;
        d1_waddr = {idx1, wr_w};
        d1_wdata = d2_rdata;
        d2_raddr = {idx2, rd_w};
        d2_we    = 1'b0;
        d2_waddr = {idx2, wr_w};
        d2_wdata = m_rdata;
        m_raddr  = MWORD_W'({r_b, rd_w});
        m_we     = 1'b0;
        m_waddr  = MWORD_W'({r_vb2, wr_w});
        m_wdata  = d2_rdata;
        case (r_state)
            S_CLR: begin
                t1_we = 1'b1; t1_waddr = IDX1_W'(r_clr); t1_wdata = '0;
                t2_we = 1'b1; t2_waddr = IDX2_W'(r_clr); t2_wdata = '0;
                m_we  = 1'b1; m_waddr  = MWORD_W'(r_clr); m_wdata = '0;
            end
            S_ACC: begin
                t1_we = 1'b1;
                if (r_req.cmd == wbc_pkg::CMD_WRITE) begin
                    d1_we    = 1'b1;
                    d1_waddr = {idx1, word};
                    d1_wdata = r_req.write_word;
                end
            end
            S_COPY: begin
                if (r_cnt != '0) begin
                    case (r_ck)
                        wbc_pkg::CK_L2_TO_MEM: m_we = 1'b1;
                        wbc_pkg::CK_MEM_TO_L2: d2_we = 1'b1;
                        wbc_pkg::CK_L1_TO_L2: begin
                            d2_we = 1'b1;
                            d2_wdata = d1_rdata;
                        end
                        wbc_pkg::CK_L2_TO_L1: d1_we = 1'b1;
                        default: ;
                    endcase
                end
                if (copy_end && r_ck == wbc_pkg::CK_MEM_TO_L2) begin
                    t2_we = 1'b1;
                end
                if (copy_end && r_ck == wbc_pkg::CK_L1_TO_L2) begin
                    t2_we = 1'b1;
                    t2_wdata = {1'b1, 1'b1, btag2};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        chg     = 1'b0;
        chg_val = r_cfg[wbc_pkg::CFG_L1_RD];
        case (r_state)
            S_CLR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start && !in_err) begin
                    n_state = S_LOOK1;
                end
            end
            S_LOOK1: begin
                if (t1_rdata[TAG1_W+1] && t1_rdata[TAG1_W-1:0] == tag1) begin
                    n_state = S_ACC;
                end else begin
                    n_state = S_E_RD;
                end
            end
            S_E_RD: n_state = S_E_LOOK;
            S_E_LOOK: begin
                if (t2_rdata[TAG2_W+1] && t2_rdata[TAG2_W-1:0] == btag2) begin
                    n_state = S_XFER;
                end else begin
                    n_state = S_COPY;
                    chg = 1'b1;
                    chg_val = (t2_rdata[TAG2_W+1] && t2_rdata[TAG2_W])
                        ? r_cfg[wbc_pkg::CFG_MEM_WR] : r_cfg[wbc_pkg::CFG_MEM_RD];
                end
            end
            S_XFER: begin
                n_state = S_COPY;
                chg = 1'b1;
                chg_val = r_vict ? r_cfg[wbc_pkg::CFG_L2_WR] : r_cfg[wbc_pkg::CFG_L2_RD];
            end
            S_COPY: begin
                if (copy_end) begin
                    case (r_ck)
                        wbc_pkg::CK_L2_TO_MEM: begin
                            chg = 1'b1;
                            chg_val = r_cfg[wbc_pkg::CFG_MEM_RD];
                        end
                        wbc_pkg::CK_MEM_TO_L2: n_state = S_XFER;
                        wbc_pkg::CK_L1_TO_L2:  n_state = S_E_RD;
                        wbc_pkg::CK_L2_TO_L1:  n_state = S_ACC;
                        default:               n_state = S_ACC;
                    endcase
                end
            end
            S_ACC: begin
                n_state = S_FIN;
                chg = 1'b1;
                chg_val = (r_req.cmd == wbc_pkg::CMD_WRITE)
                    ? r_cfg[wbc_pkg::CFG_L1_WR] : r_cfg[wbc_pkg::CFG_L1_RD];
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_total <= '0;
            r_cfg[wbc_pkg::CFG_L1_RD]  <= wbc_pkg::RST_L1_COST;
            r_cfg[wbc_pkg::CFG_L1_WR]  <= wbc_pkg::RST_L1_COST;
            r_cfg[wbc_pkg::CFG_L2_RD]  <= wbc_pkg::RST_L2_COST;
            r_cfg[wbc_pkg::CFG_L2_WR]  <= wbc_pkg::RST_L2_COST;
            r_cfg[wbc_pkg::CFG_MEM_RD] <= wbc_pkg::RST_MEM_COST;
            r_cfg[wbc_pkg::CFG_MEM_WR] <= wbc_pkg::RST_MEM_COST;
        end else begin
            r_state <= n_state;
            r_ov    <= (accept && in_err) || (r_state == S_FIN);
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wbc_pkg::CFG_L1_RD:  r_cfg[wbc_pkg::CFG_L1_RD]  <= i_cfg_data;
                    wbc_pkg::CFG_L1_WR:  r_cfg[wbc_pkg::CFG_L1_WR]  <= i_cfg_data;
                    wbc_pkg::CFG_L2_RD:  r_cfg[wbc_pkg::CFG_L2_RD]  <= i_cfg_data;
                    wbc_pkg::CFG_L2_WR:  r_cfg[wbc_pkg::CFG_L2_WR]  <= i_cfg_data;
                    wbc_pkg::CFG_MEM_RD: r_cfg[wbc_pkg::CFG_MEM_RD] <= i_cfg_data;
                    wbc_pkg::CFG_MEM_WR: r_cfg[wbc_pkg::CFG_MEM_WR] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (chg) begin
                r_total <= r_total + 32'(chg_val);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_step <= '0;
            r_hit2 <= 1'b0;
            if (in_err) begin
                r_rsp <= '{read_word: 32'd0, l1_hit: 1'b0, l2_hit: 1'b0,
                           access_cost: '0, total_cost: r_total, error: 1'b1};
            end
        end else if (chg) begin
            r_step <= r_step + STEP_W'(chg_val);
        end
        case (r_state)
            S_LOOK1: begin
                r_t1   <= t1_rdata;
                r_hit1 <= t1_rdata[TAG1_W+1] && t1_rdata[TAG1_W-1:0] == tag1;
                r_vict <= t1_rdata[TAG1_W+1] && t1_rdata[TAG1_W];
                r_b    <= (t1_rdata[TAG1_W+1] && t1_rdata[TAG1_W])
                    ? BLK_W'({t1_rdata[TAG1_W-1:0], idx1}) : blk;
            end
            S_E_LOOK: begin
                r_cnt  <= '0;
                r_ehit <= t2_rdata[TAG2_W+1] && t2_rdata[TAG2_W-1:0] == btag2;
                r_vb2  <= BLK_W'({t2_rdata[TAG2_W-1:0], idx2});
                r_ck   <= (t2_rdata[TAG2_W+1] && t2_rdata[TAG2_W])
                    ? wbc_pkg::CK_L2_TO_MEM : wbc_pkg::CK_MEM_TO_L2;
            end
            S_XFER: begin
                r_cnt <= '0;
                if (r_vict) begin
                    r_ck <= wbc_pkg::CK_L1_TO_L2;
                end else begin
                    r_ck   <= wbc_pkg::CK_L2_TO_L1;
                    r_hit2 <= r_ehit;
                end
            end
            S_COPY: begin
                if (copy_end) begin
                    r_cnt <= '0;
                    if (r_ck == wbc_pkg::CK_L2_TO_MEM) begin
                        r_ck <= wbc_pkg::CK_MEM_TO_L2;
                    end
                    if (r_ck == wbc_pkg::CK_L1_TO_L2) begin
                        r_vict <= 1'b0;
                        r_b    <= blk;
                    end
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                r_rsp <= '{read_word: (r_req.cmd == wbc_pkg::CMD_WRITE) ? 32'd0 : d1_rdata,
                           l1_hit: r_hit1, l2_hit: r_hit2, access_cost: r_step,
                           total_cost: r_total, error: 1'b0};
            end
            default: ;
        endcase
    end

    wbc_ram #(.ADDR_W(IDX1_W), .DATA_W(T1_W)) u_l1_tag (
        .i_clk(i_clk), .i_we(t1_we), .i_waddr(t1_waddr), .i_wdata(t1_wdata),
        .i_raddr(t1_raddr), .o_rdata(t1_rdata)
    );

    wbc_ram #(.ADDR_W(IDX2_W), .DATA_W(T2_W)) u_l2_tag (
        .i_clk(i_clk), .i_we(t2_we), .i_waddr(t2_waddr), .i_wdata(t2_wdata),
        .i_raddr(idx2), .o_rdata(t2_rdata)
    );

    wbc_ram #(.ADDR_W(IDX1_W + W_W), .DATA_W(32)) u_l1_data (
        .i_clk(i_clk), .i_we(d1_we), .i_waddr(d1_waddr), .i_wdata(d1_wdata),
        .i_raddr(d1_raddr), .o_rdata(d1_rdata)
    );

    wbc_ram #(.ADDR_W(IDX2_W + W_W), .DATA_W(32)) u_l2_data (
        .i_clk(i_clk), .i_we(d2_we), .i_waddr(d2_waddr), .i_wdata(d2_wdata),
        .i_raddr(d2_raddr), .o_rdata(d2_rdata)
    );

    wbc_ram #(.ADDR_W(MWORD_W), .DATA_W(32)) u_backing (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

endmodule

// File: rtl/wbc_checker.sv
// Port-level checker of the cache core and its bind.
`timescale 1ns / 1ps
module wbc_checker #(
    parameter int MEM_BYTES = 1048576
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input wbc_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input wbc_pkg::t_rsp o_rsp
);

    localparam int MEM_W = $clog2(MEM_BYTES);

    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_err_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && ((i_req.address >> MEM_W) != 32'd0)
        |=> o_rsp_valid && o_rsp.error)
        else $error("out-of-range word not flagged");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.error |-> o_rsp.read_word == 32'd0 &&
        !o_rsp.l1_hit && !o_rsp.l2_hit && o_rsp.access_cost == '0)
        else $error("error result carries data");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.l1_hit && o_rsp.l2_hit))
        else $error("both hit flags set");

endmodule

bind two_level_write_back_cache_core wbc_checker #(.MEM_BYTES(MEM_BYTES)) u_wbc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_req(i_req), .o_rsp_valid(o_rsp_valid), .o_rsp(o_rsp)
);

// File: tb/sv/tb_two_level_write_back_cache_core.sv
// Testbench: random and directed word accesses checked against a cache and cost predictor.
`timescale 1ns / 1ps
module tb_two_level_write_back_cache_core;

    localparam int WPL        = 16;
    localparam int MEM_BLOCKS = 16384;
    localparam int LIMIT      = 3000000;

    class cache_scoreboard;
        bit [15:0] cost [6];
        bit        l1v [256];
        bit        l1d [256];
        bit [17:0] l1t [256];
        bit [31:0] l1w [4096];
        bit        l2v [512];
        bit        l2d [512];
        bit [16:0] l2t [512];
        bit [31:0] l2w [8192];
        bit [31:0] mem [262144];
        bit [31:0] total;
        bit [31:0] step;
        wbc_pkg::t_rsp pending [$];
        int        n_l1_hit, n_l2_hit, n_err;

        function new();
            cost[wbc_pkg::CFG_L1_RD]  = wbc_pkg::RST_L1_COST;
            cost[wbc_pkg::CFG_L1_WR]  = wbc_pkg::RST_L1_COST;
            cost[wbc_pkg::CFG_L2_RD]  = wbc_pkg::RST_L2_COST;
            cost[wbc_pkg::CFG_L2_WR]  = wbc_pkg::RST_L2_COST;
            cost[wbc_pkg::CFG_MEM_RD] = wbc_pkg::RST_MEM_COST;
            cost[wbc_pkg::CFG_MEM_WR] = wbc_pkg::RST_MEM_COST;
        endfunction

        function void set_cost(bit [2:0] idx, bit [15:0] val);
            if (idx < 6) cost[idx] = val;
        endfunction

        function void charge(bit [15:0] c);
            step  += c;
            total += c;
        endfunction

        function bit l2_fetch(int unsigned blk);
            int unsigned ix, vb;
            ix = blk % 512;
            if (l2v[ix] && l2t[ix] == blk / 512) return 1;
            if (l2v[ix] && l2d[ix]) begin
                vb = (l2t[ix] * 512 + ix) % MEM_BLOCKS;
                for (int i = 0; i < WPL; i++) mem[vb*WPL+i] = l2w[ix*WPL+i];
                charge(cost[wbc_pkg::CFG_MEM_WR]);
            end
            for (int i = 0; i < WPL; i++) l2w[ix*WPL+i] = mem[blk*WPL+i];
            charge(cost[wbc_pkg::CFG_MEM_RD]);
            l2v[ix] = 1;
            l2t[ix] = 17'(blk / 512);
            l2d[ix] = 0;
            return 0;
        endfunction

        function void note(wbc_pkg::t_req rq);
            int unsigned   blk, ix, wd, vb;
            bit            h1, h2, dummy;
            wbc_pkg::t_rsp r;
            blk  = rq.address / 64;
            wd   = (rq.address % 64) / 4;
            step = 0;
            r    = '0;
            if (blk >= MEM_BLOCKS) begin
                r.total_cost = total;
                r.error      = 1'b1;
                n_err++;
                pending.push_back(r);
                return;
            end
            ix = blk % 256;
            h1 = l1v[ix] && l1t[ix] == blk / 256;
            h2 = 0;
            if (!h1) begin
                if (l1v[ix] && l1d[ix]) begin
                    vb    = (l1t[ix] * 256 + ix) % MEM_BLOCKS;
                    dummy = l2_fetch(vb);
                    for (int i = 0; i < WPL; i++) l2w[(vb%512)*WPL+i] = l1w[ix*WPL+i];
                    l2d[vb%512] = 1;
                    charge(cost[wbc_pkg::CFG_L2_WR]);
                end
                h2 = l2_fetch(blk);
                for (int i = 0; i < WPL; i++) l1w[ix*WPL+i] = l2w[(blk%512)*WPL+i];
                charge(cost[wbc_pkg::CFG_L2_RD]);
                l1v[ix] = 1;
                l1t[ix] = 18'(blk / 256);
                l1d[ix] = 0;
            end
            if (rq.cmd == wbc_pkg::CMD_READ) begin
                r.read_word = l1w[ix*WPL+wd];
                charge(cost[wbc_pkg::CFG_L1_RD]);
            end else begin
                l1w[ix*WPL+wd] = rq.write_word;
                l1d[ix] = 1;
                charge(cost[wbc_pkg::CFG_L1_WR]);
            end
            r.l1_hit      = h1;
            r.l2_hit      = h2;
            r.access_cost = step[19:0];
            r.total_cost  = total;
            n_l1_hit += h1;
            n_l2_hit += h2;
            pending.push_back(r);
        endfunction

        function string check(wbc_pkg::t_rsp got);
            wbc_pkg::t_rsp e;
            string         s;
            if (pending.size() == 0) return "result with nothing outstanding";
            e = pending.pop_front();
            s = "";
            if (got.read_word !== e.read_word)
                s = {s, $sformatf(" read_word %h/%h", got.read_word, e.read_word)};
            if (got.l1_hit !== e.l1_hit)
                s = {s, $sformatf(" l1_hit %b/%b", got.l1_hit, e.l1_hit)};
            if (got.l2_hit !== e.l2_hit)
                s = {s, $sformatf(" l2_hit %b/%b", got.l2_hit, e.l2_hit)};
            if (got.access_cost !== e.access_cost)
                s = {s, $sformatf(" access_cost %0d/%0d", got.access_cost, e.access_cost)};
            if (got.total_cost !== e.total_cost)
                s = {s, $sformatf(" total_cost %0d/%0d", got.total_cost, e.total_cost)};
            if (got.error !== e.error)
                s = {s, $sformatf(" error %b/%b", got.error, e.error)};
            return s;
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    wbc_pkg::t_req                 i_req       = '0;
    logic                          o_rsp_valid;
    wbc_pkg::t_rsp                 o_rsp;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [wbc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [wbc_pkg::COST_W-1:0]    i_cfg_data  = '0;

    cache_scoreboard sb = new();
    int errors = 0;
    int cycles = 0;
    int n_items = 0;

    two_level_write_back_cache_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("[%0d] bad result:%s", cycles, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        string msg;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("two_level_write_back_cache_core: mismatch");
            $finish;
        end
        if (i_rst_n && o_rsp_valid) begin
            msg = sb.check(o_rsp);
            if (msg != "") report(msg);
        end
    end

    task automatic send(logic cmd, logic [31:0] addr, logic [31:0] wd);
        wbc_pkg::t_req rq;
        rq.cmd = cmd;
        rq.address = addr;
        rq.write_word = wd;
        i_req <= rq;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(rq);
        n_items++;
    endtask

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_cost(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_cost(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr();
        int unsigned blk, r;
        r = $urandom_range(0, 99);
        if (r < 5) return $urandom | 32'h0010_0000;
        if (r < 15) blk = $urandom_range(0, MEM_BLOCKS - 1);
        else blk = ($urandom_range(0, 7) << 8) | $urandom_range(0, 7);
        return blk * 64 + $urandom_range(0, 63);
    endfunction

    task automatic random_phase(int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 14);
            while (burst > 0 && left > 0) begin
                send(1'($urandom_range(0, 1)), pick_addr(), $urandom);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
        end
        idle(0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cost(3'd6, 16'hFFFF);
        write_cost(3'd7, 16'h1234);

        send(wbc_pkg::CMD_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        send(wbc_pkg::CMD_READ,  32'h0000_0003, 32'h0);
        send(wbc_pkg::CMD_WRITE, 32'h0000_4000, 32'hA5A5_0001);
        send(wbc_pkg::CMD_WRITE, 32'h0000_8000, 32'h0000_0002);
        send(wbc_pkg::CMD_READ,  32'h0000_C03C, 32'hFFFF_FFFF);
        send(wbc_pkg::CMD_READ,  32'h0000_0000, 32'h0);
        send(wbc_pkg::CMD_READ,  32'h0000_4000, 32'h0);
        send(wbc_pkg::CMD_READ,  32'h0000_8001, 32'h0);
        send(wbc_pkg::CMD_WRITE, 32'h000F_FFFC, 32'h8000_0000);
        send(wbc_pkg::CMD_READ,  32'h000F_FFFF, 32'h0);
        send(wbc_pkg::CMD_WRITE, 32'h0010_0000, 32'hDEAD_BEEF);
        send(wbc_pkg::CMD_READ,  32'hFFFF_FFFF, 32'h0);
        send(wbc_pkg::CMD_READ,  32'h0008_0000, 32'h0);
        send(wbc_pkg::CMD_READ,  32'h0000_0000, 32'h0);
        send(wbc_pkg::CMD_WRITE, 32'h0000_0040, 32'h1);
        send(wbc_pkg::CMD_READ,  32'h0000_0040, 32'h0);
        idle(0);
        drain();

        random_phase(180);
        drain();
        for (int i = 0; i < 6; i++) write_cost(i[2:0], 16'hFFFF);
        random_phase(170);
        drain();
        for (int i = 0; i < 6; i++) write_cost(i[2:0], 16'h0000);
        random_phase(170);
        drain();
        for (int i = 0; i < 6; i++) write_cost(i[2:0], 16'($urandom));
        random_phase(170);
        drain();

        $display("%0d accesses: %0d L1 hits, %0d L2 hits, %0d out-of-range", n_items,
                 sb.n_l1_hit, sb.n_l2_hit, sb.n_err);
        $display("cost settings: reset, all max, all zero, random");
        if (errors == 0) begin
            $display("two_level_write_back_cache_core: match");
        end else begin
            $display("two_level_write_back_cache_core: mismatch");
        end
        $finish;
    end
endmodule
